FILE: src/blp_pkg.sv
// ----------------------------------------------------------------------------
// blp_pkg: shared types and constants of the line plotter
// Command encoding, the classified command that travels between the front
// and back ends, and a small helper used by the front end.
// ----------------------------------------------------------------------------
package blp_pkg;

   localparam int COORD_BITS  = 6;
   localparam int VALUE_BITS  = 16;
   localparam int DATA_BITS   = 16;
   localparam int CMD_Q_DEPTH = 2;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef enum logic [1:0] {
      OP_DRAW_SET = 2'd0,
      OP_DRAW_ADD = 2'd1,
      OP_READ     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   // Classified command: line already put in major/minor axis order.
   // Reads use maj_start as column and min_start as row.
   typedef struct packed {
      op_type                op;
      logic                  steep;
      coord_type             maj_start;
      coord_type             maj_end;
      coord_type             min_start;
      coord_type             dmaj;
      coord_type             dmin;
      logic                  step_neg;
      logic [VALUE_BITS-1:0] value;
   } cmd_type;

   // Absolute difference of two coordinates
   function automatic coord_type span(coord_type a, coord_type b);
      coord_type d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

endpackage

FILE: src/blp_ram.sv
// ----------------------------------------------------------------------------
// blp_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module blp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/blp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// blp_cmd_fifo: short command queue between front and back end
// Holds classified commands so the front can take a transaction while the
// back end is still tracing a line.
// ----------------------------------------------------------------------------
module blp_cmd_fifo import blp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output cmd_type head
);

   localparam int PW = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
   localparam int CW = $clog2(CMD_Q_DEPTH + 1);

   cmd_type         slot_ff [CMD_Q_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff,  count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(CMD_Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = slot_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/blp_front.sv
// ----------------------------------------------------------------------------
// blp_front: request decode and line setup
// Takes request transactions, drops unused opcodes, and turns a draw into
// major/minor axis form (steep swap, endpoint ordering, spans, step sign).
// ----------------------------------------------------------------------------
module blp_front import blp_pkg::*; (
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_op,
   input  coord_type             req_start_x,
   input  coord_type             req_start_y,
   input  coord_type             req_end_x,
   input  coord_type             req_end_y,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  q_full,
   input  logic                  clearing,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   op_type    op;
   coord_type dx, dy;
   logic      steep, swap;
   coord_type a_maj, a_min, b_maj, b_min;
   coord_type maj0, maj1, min0, min1;

   assign op = op_type'(req_op);

   // no new transaction while the queue is full or the grid is being cleared
   assign full   = q_full | clearing;
   assign q_push = push & ~full & (op != OP_NONE);

   // classification
   always_comb begin
      dx    = span(req_end_x, req_start_x);
      dy    = span(req_end_y, req_start_y);
      steep = (dy > dx);
      a_maj = steep ? req_start_y : req_start_x;
      a_min = steep ? req_start_x : req_start_y;
      b_maj = steep ? req_end_y   : req_end_x;
      b_min = steep ? req_end_x   : req_end_y;
      swap  = (a_maj > b_maj);
      maj0  = swap ? b_maj : a_maj;
      maj1  = swap ? a_maj : b_maj;
      min0  = swap ? b_min : a_min;
      min1  = swap ? a_min : b_min;

      q_cmd.op        = op;
      q_cmd.steep     = steep;
      q_cmd.maj_start = maj0;
      q_cmd.maj_end   = maj1;
      q_cmd.min_start = min0;
      q_cmd.dmaj      = maj1 - maj0;
      q_cmd.dmin      = span(min0, min1);
      q_cmd.step_neg  = ~(min0 < min1);
      q_cmd.value     = req_value;

      // reads address one cell: column on the major slot, row on the minor
      if (op == OP_READ) begin
         q_cmd.steep     = 1'b0;
         q_cmd.maj_start = req_start_x;
         q_cmd.maj_end   = req_start_x;
         q_cmd.min_start = req_start_y;
      end
   end

endmodule

FILE: src/blp_back.sv
// ----------------------------------------------------------------------------
// blp_back: grid sequencer
// Clears the grid after reset, steps Bresenham lines one cell per cycle with
// a read-modify-write pipeline on the grid RAM, and serves cell reads into a
// one-entry response register.
// ----------------------------------------------------------------------------
module blp_back import blp_pkg::*; #(
   parameter int GRID_SIZE = 64,
   parameter int CELL_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  cmd_type              q_head,
   output logic                 q_pop,
   output logic                 clearing,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [DATA_BITS-1:0] rsp_cell_data
);

   localparam int DEPTH   = GRID_SIZE * GRID_SIZE;
   localparam int AW      = $clog2(DEPTH);
   localparam int IDXW0   = COORD_BITS + $clog2(GRID_SIZE) + 1;
   localparam int IDXW    = (IDXW0 > AW) ? IDXW0 : AW;
   localparam int SW      = ((CELL_BITS > VALUE_BITS) ? CELL_BITS : VALUE_BITS) + 1;
   localparam int ERRW    = COORD_BITS + 2;
   localparam logic [SW-1:0] CELL_MAX = SW'((64'd1 << CELL_BITS) - 64'd1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRAW
   } state_type;

   state_type              state_ff,    state_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   coord_type              major_ff,    major_in;
   coord_type              maj_end_ff,  maj_end_in;
   coord_type              minor_ff,    minor_in;
   logic signed [ERRW-1:0] err_ff,      err_in;
   coord_type              dmaj_ff,     dmaj_in;
   coord_type              dmin_ff,     dmin_in;
   logic                   steep_ff,    steep_in;
   logic                   neg_ff,      neg_in;
   logic                   add_ff,      add_in;
   logic [VALUE_BITS-1:0]  val_ff,      val_in;
   logic                   wr_pend_ff,  wr_pend_in;
   logic [AW-1:0]          wr_addr_ff,  wr_addr_in;
   logic                   rd_pend_ff,  rd_pend_in;
   logic                   rd_ok_ff,    rd_ok_in;
   logic                   rsp_vld_ff,  rsp_vld_in;
   logic [DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;

   coord_type              cell_x, cell_y;
   logic                   cell_ok;
   logic [IDXW-1:0]        cell_idx;
   logic [AW-1:0]          cell_addr;
   logic signed [ERRW-1:0] err_dec;

   logic                   ram_wr_en, ram_rd_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [CELL_BITS-1:0]   ram_wr_data, ram_rd_data;
   logic [SW-1:0]          new_val, sat_val;

   assign clearing      = (state_ff == ST_CLEAR);
   assign rsp_empty     = ~rsp_vld_ff;
   assign rsp_cell_data = rsp_data_ff;

   // cell under the cursor: the stepping registers while drawing, else the queue head
   always_comb begin
      if (state_ff == ST_DRAW) begin
         cell_x = steep_ff ? minor_ff : major_ff;
         cell_y = steep_ff ? major_ff : minor_ff;
      end else begin
         cell_x = q_head.maj_start;
         cell_y = q_head.min_start;
      end
      cell_ok   = (IDXW'(cell_x) < IDXW'(GRID_SIZE)) && (IDXW'(cell_y) < IDXW'(GRID_SIZE));
      cell_idx  = IDXW'(cell_x) * IDXW'(GRID_SIZE) + IDXW'(cell_y);
      cell_addr = cell_idx[AW-1:0];
   end

   // write stage: set or saturating add on the cell read last cycle
   always_comb begin
      new_val     = add_ff ? (SW'(ram_rd_data) + SW'(val_ff)) : SW'(val_ff);
      sat_val     = (new_val > CELL_MAX) ? CELL_MAX : new_val;
      ram_wr_en   = clearing | wr_pend_ff;
      ram_wr_addr = clearing ? clr_addr_ff : wr_addr_ff;
      ram_wr_data = clearing ? '0 : sat_val[CELL_BITS-1:0];
   end

   assign err_dec = err_ff - $signed(ERRW'(dmin_ff));

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      major_in    = major_ff;
      maj_end_in  = maj_end_ff;
      minor_in    = minor_ff;
      err_in      = err_ff;
      dmaj_in     = dmaj_ff;
      dmin_in     = dmin_ff;
      steep_in    = steep_ff;
      neg_in      = neg_ff;
      add_in      = add_ff;
      val_in      = val_ff;
      wr_pend_in  = 1'b0;
      wr_addr_in  = wr_addr_ff;
      rd_pend_in  = 1'b0;
      rd_ok_in    = rd_ok_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      q_pop       = 1'b0;
      ram_rd_en   = 1'b0;

      // response register
      if (rsp_pop && rsp_vld_ff) begin
         rsp_vld_in = 1'b0;
      end
      if (rd_pend_ff) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = rd_ok_ff ? DATA_BITS'(ram_rd_data) : '0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            // wait for the RAM pipeline to drain so no read sees a stale cell
            if (!q_empty && !wr_pend_ff && !rd_pend_ff) begin
               if (q_head.op == OP_READ) begin
                  if (!rsp_vld_ff) begin
                     q_pop      = 1'b1;
                     ram_rd_en  = cell_ok;
                     rd_pend_in = 1'b1;
                     rd_ok_in   = cell_ok;
                  end
               end else begin
                  q_pop      = 1'b1;
                  major_in   = q_head.maj_start;
                  maj_end_in = q_head.maj_end;
                  minor_in   = q_head.min_start;
                  err_in     = $signed(ERRW'(q_head.dmaj >> 1));
                  dmaj_in    = q_head.dmaj;
                  dmin_in    = q_head.dmin;
                  steep_in   = q_head.steep;
                  neg_in     = q_head.step_neg;
                  add_in     = (q_head.op == OP_DRAW_ADD);
                  val_in     = q_head.value;
                  state_in   = ST_DRAW;
               end
            end
         end
         ST_DRAW: begin
            // read this cell, write it next cycle; off-grid cells are skipped
            ram_rd_en  = cell_ok;
            wr_pend_in = cell_ok;
            wr_addr_in = cell_addr;
            if (err_dec < 0) begin
               minor_in = neg_ff ? (minor_ff - 1'b1) : (minor_ff + 1'b1);
               err_in   = err_dec + $signed(ERRW'(dmaj_ff));
            end else begin
               err_in   = err_dec;
            end
            if (major_ff == maj_end_ff) begin
               state_in = ST_IDLE;
            end else begin
               major_in = major_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         wr_pend_ff  <= 1'b0;
         rd_pend_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         wr_pend_ff  <= wr_pend_in;
         rd_pend_ff  <= rd_pend_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      major_ff    <= major_in;
      maj_end_ff  <= maj_end_in;
      minor_ff    <= minor_in;
      err_ff      <= err_in;
      dmaj_ff     <= dmaj_in;
      dmin_ff     <= dmin_in;
      steep_ff    <= steep_in;
      neg_ff      <= neg_in;
      add_ff      <= add_in;
      val_ff      <= val_in;
      wr_addr_ff  <= wr_addr_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   blp_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cell_addr),
      .rd_data (ram_rd_data)
   );

endmodule

FILE: src/bresenham_line_plotter.sv
// ----------------------------------------------------------------------------
// bresenham_line_plotter: line drawing engine on a square cell grid
// Request queue in (push/full), response queue out (empty/pop).
//
// Usage:
//   A request transaction carries an opcode, two endpoints and a value.
//   Draw-set overwrites every cell on the line with the value (saturated to
//   the cell width); draw-add adds it with saturation. A read returns one
//   cell on rsp_cell_data; off-grid reads return zero. Opcode 3 is dropped.
//   Draws produce no response.
// Timing:
//   After reset the grid RAM is cleared one cell per cycle, and full stays
//   high during that pass. A draw occupies the back end while it steps its
//   cells, one RAM read-modify-write per cell. A read passes from the queue
//   head through the registered RAM read into the response register, and
//   holds the back end until its RAM read is done.
//   A two-entry command queue lets requests land while a line is traced.
//   If the receiver does not pop, the response register holds its data; the
//   next read waits at the queue head and holds back everything behind it,
//   so the queue fills and full goes high.
// ----------------------------------------------------------------------------
module bresenham_line_plotter import blp_pkg::*; #(
   parameter int GRID_SIZE = 64,
   parameter int CELL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_op,
   input  logic [5:0]            req_start_x,
   input  logic [5:0]            req_start_y,
   input  logic [5:0]            req_end_x,
   input  logic [5:0]            req_end_y,
   input  logic [15:0]           req_value,
   output logic                  empty,
   input  logic                  pop,
   output logic [15:0]           rsp_cell_data
);

   logic    q_push, q_full, q_empty, q_pop, clearing;
   cmd_type q_cmd, q_head;

   blp_front u_front (
      .push        (push),
      .full        (full),
      .req_op      (req_op),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .req_value   (req_value),
      .q_full      (q_full),
      .clearing    (clearing),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   blp_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .empty    (q_empty),
      .pop      (q_pop),
      .head     (q_head)
   );

   blp_back #(
      .GRID_SIZE (GRID_SIZE),
      .CELL_BITS (CELL_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .clearing      (clearing),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp_cell_data (rsp_cell_data)
   );

endmodule

FILE: src/blp_checker.sv
// ----------------------------------------------------------------------------
// blp_checker: port-level checks of the line plotter
// Watches reset behavior, response stability and that every response is
// backed by an accepted read transaction.
// ----------------------------------------------------------------------------
module blp_checker import blp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic [1:0]  req_op,
   input logic        empty,
   input logic        pop,
   input logic [15:0] rsp_cell_data
);

   // reads accepted but not yet popped
   logic [2:0] reads_ff, reads_in;
   logic       rd_acc, rsp_acc;

   assign rd_acc  = push & ~full & (op_type'(req_op) == OP_READ);
   assign rsp_acc = pop & ~empty;

   always_comb begin
      reads_in = reads_ff;
      if (rd_acc && !rsp_acc) begin
         reads_in = reads_ff + 1'b1;
      end else if (rsp_acc && !rd_acc) begin
         reads_in = reads_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reads_ff <= '0;
      end else begin
         reads_ff <= reads_in;
      end
   end

   // reset empties the response side
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("response pending right after reset");

   // grid clear pass blocks requests right after reset
   a_reset_full: assert property (@(posedge clock) reset |=> full)
      else $error("request taken during grid clear");

   // a waiting response holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_cell_data))
      else $error("response changed while stalled");

   // no response without an outstanding read
   a_rsp_backed: assert property (@(posedge clock) disable iff (reset)
      !empty |-> reads_ff != 3'd0)
      else $error("response with no accepted read");

endmodule

bind bresenham_line_plotter blp_checker u_blp_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Bresenham line plotter
// A short table of directed transactions is sent first, then random draw,
// read and unused-opcode transactions. A behavioral copy of the grid traces
// every accepted line and predicts each read without a typed-in result. Both
// sides idle at random, the receiver holds off once so that the block fills
// up, and the sender pauses until every response has arrived between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import blp_pkg::*;

   localparam int GRID_DIM        = 64;
   localparam int DRAIN_CYCLES    = 70;    // one full-length line plus margin
   localparam int HOLD_CYCLES     = 400;
   localparam int ITEMS_PER_PHASE = 560;

   typedef struct {
      op_type      op;
      coord_type   sx;
      coord_type   sy;
      coord_type   ex;
      coord_type   ey;
      logic [15:0] value;
      bit          known;
      logic [15:0] known_data;
   } stim_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        push        = 1'b0;
   logic        full;
   op_type      req_op      = OP_NONE;
   coord_type   req_start_x = '0;
   coord_type   req_start_y = '0;
   coord_type   req_end_x   = '0;
   coord_type   req_end_y   = '0;
   logic [15:0] req_value   = '0;
   logic        empty;
   logic        pop         = 1'b0;
   logic [15:0] rsp_cell_data;

   // Typed-in expectation travels with the request it belongs to
   bit          req_known      = 1'b0;
   logic [15:0] req_known_data = '0;

   logic [15:0]  grid_image [GRID_DIM*GRID_DIM];
   logic [15:0]  cell_data_expect_q [$];
   stim_row_type directed_q [$];
   int           error_count   = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   bit           hold_request  = 1'b0;
   coord_type    last_end_x    = '0;
   coord_type    last_end_y    = '0;

   bresenham_line_plotter i_dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_op        (req_op),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_value     (req_value),
      .empty         (empty),
      .pop           (pop),
      .rsp_cell_data (rsp_cell_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------------
   // Grid predictor
   // ------------------------------------------------------------------------
   function automatic int axis_span(int a, int b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Set or saturating add on one cell; off-grid cells are skipped
   function automatic void touch_cell(int x, int y, logic [15:0] val, bit add_mode);
      logic [16:0] sum;
      if (x < 0 || y < 0 || x >= GRID_DIM || y >= GRID_DIM)
         return;
      if (add_mode) begin
         sum = {1'b0, grid_image[x*GRID_DIM+y]} + {1'b0, val};
         grid_image[x*GRID_DIM+y] = sum[16] ? 16'hFFFF : sum[15:0];
      end else begin
         grid_image[x*GRID_DIM+y] = val;
      end
   endfunction

   function automatic void plot_line(int ax, int ay, int bx, int by,
                                     logic [15:0] val, bit add_mode);
      int tmp;
      int dmaj;
      int dmin;
      int err;
      int step;
      int minor;
      bit steep;
      steep = axis_span(by, ay) > axis_span(bx, ax);
      // steep lines walk along rows
      if (steep) begin
         tmp = ax; ax = ay; ay = tmp;
         tmp = bx; bx = by; by = tmp;
      end
      if (ax > bx) begin
         tmp = ax; ax = bx; bx = tmp;
         tmp = ay; ay = by; by = tmp;
      end
      dmaj  = bx - ax;
      dmin  = axis_span(by, ay);
      err   = dmaj / 2;
      step  = (ay < by) ? 1 : -1;
      minor = ay;
      for (int major = ax; major <= bx; major++) begin
         if (steep)
            touch_cell(minor, major, val, add_mode);
         else
            touch_cell(major, minor, val, add_mode);
         err -= dmin;
         if (err < 0) begin
            minor += step;
            err   += dmaj;
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request monitor: update the grid copy on each accepted transaction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         case (req_op)
            OP_DRAW_SET, OP_DRAW_ADD: begin
               plot_line(req_start_x, req_start_y, req_end_x, req_end_y, req_value,
                         req_op == OP_DRAW_ADD);
            end
            OP_READ: begin
               cell_data_expect_q.push_back(req_known ? req_known_data :
                  grid_image[req_start_x*GRID_DIM + req_start_y]);
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Response checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && pop && !empty) begin
         if (cell_data_expect_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, actual cell_data %h",
                     $time, rsp_cell_data);
         end else begin
            want = cell_data_expect_q.pop_front();
            if (rsp_cell_data !== want) begin
               error_count++;
               $display("%0t: cell_data mismatch, expected %h, actual %h",
                        $time, want, rsp_cell_data);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random pop, with one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------
   task automatic send_item(op_type op, coord_type sx, coord_type sy, coord_type ex,
                            coord_type ey, logic [15:0] value, bit known,
                            logic [15:0] known_data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_op         <= op;
      req_start_x    <= sx;
      req_start_y    <= sy;
      req_end_x      <= ex;
      req_end_y      <= ey;
      req_value      <= value;
      req_known      <= known;
      req_known_data <= known_data;
      @(posedge clock);
      while (full)
         @(posedge clock);
   endtask

   // Stop offering and wait for every outstanding response; the extra edge
   // lets the monitor record a read taken at the last accepting edge
   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (cell_data_expect_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_row(op_type op, coord_type sx, coord_type sy, coord_type ex,
                          coord_type ey, logic [15:0] value, bit known,
                          logic [15:0] known_data);
      stim_row_type row;
      row.op         = op;
      row.sx         = sx;
      row.sy         = sy;
      row.ex         = ex;
      row.ey         = ey;
      row.value      = value;
      row.known      = known;
      row.known_data = known_data;
      directed_q.push_back(row);
   endtask

   // Coordinates lean toward the grid edges
   function automatic coord_type pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      return coord_type'($urandom_range(0, GRID_DIM - 1));
   endfunction

   task automatic send_random(int count);
      op_type      op;
      coord_type   sx;
      coord_type   sy;
      coord_type   ex;
      coord_type   ey;
      logic [15:0] value;
      int          r;
      repeat (count) begin
         r  = $urandom_range(0, 99);
         op = (r < 4) ? OP_NONE : (r < 50) ? OP_READ : (r < 75) ? OP_DRAW_SET : OP_DRAW_ADD;
         sx = pick_coord();
         sy = pick_coord();
         ex = pick_coord();
         ey = pick_coord();
         r  = $urandom_range(0, 9);
         value = (r == 0) ? 16'hFFFF :
                 (r == 1) ? 16'h0000 :
                 (r < 4)  ? 16'($urandom_range(0, 255)) : 16'($urandom_range(0, 65535));
         // a third of the reads land on the end of the last line
         if (op == OP_READ && $urandom_range(0, 2) == 0) begin
            sx = last_end_x;
            sy = last_end_y;
         end
         if (op == OP_DRAW_SET || op == OP_DRAW_ADD) begin
            last_end_x = ex;
            last_end_y = ey;
         end
         send_item(op, sx, sy, ex, ey, value, 1'b0, 16'h0000);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      foreach (grid_image[i])
         grid_image[i] = '0;

      //      op           sx  sy  ex  ey  value     known data
      add_row(OP_READ,      0,  0,  0,  0, 16'h0000, 1, 16'h0000); // clear after reset
      add_row(OP_READ,     63, 63,  0,  0, 16'h0000, 1, 16'h0000);
      add_row(OP_DRAW_SET,  0,  0, 63, 63, 16'hFFFF, 0, 16'h0000); // full diagonal
      add_row(OP_READ,     63, 63,  0,  0, 16'h0000, 1, 16'hFFFF);
      add_row(OP_DRAW_ADD,  0,  0, 63,  0, 16'h0001, 0, 16'h0000); // row 0
      add_row(OP_READ,      0,  0,  0,  0, 16'h0000, 1, 16'hFFFF); // add saturates
      add_row(OP_READ,     63,  0,  0,  0, 16'h0000, 1, 16'h0001);
      add_row(OP_DRAW_SET,  5,  0,  6, 63, 16'h1234, 0, 16'h0000); // steep line
      add_row(OP_READ,      5,  0,  0,  0, 16'h0000, 0, 16'h0000);
      add_row(OP_READ,      6, 63,  0,  0, 16'h0000, 0, 16'h0000);
      add_row(OP_DRAW_ADD, 63, 10,  0, 20, 16'h8000, 0, 16'h0000); // reversed endpoints
      add_row(OP_READ,     30, 15,  0,  0, 16'h0000, 0, 16'h0000);
      add_row(OP_NONE,      2,  1,  2,  1, 16'hFFFF, 0, 16'h0000); // unused opcode
      add_row(OP_READ,      2,  1,  0,  0, 16'h0000, 1, 16'h0000);
      add_row(OP_DRAW_SET, 40, 50, 40, 50, 16'h00A5, 0, 16'h0000); // single point
      add_row(OP_READ,     40, 50,  0,  0, 16'h0000, 1, 16'h00A5);
      add_row(OP_DRAW_ADD, 10, 63,  0,  0, 16'h7FFF, 0, 16'h0000); // steep, reversed endpoints
      add_row(OP_READ,      0,  0,  0,  0, 16'h0000, 0, 16'h0000);
      add_row(OP_READ,      5, 31,  0,  0, 16'h0000, 0, 16'h0000);
      add_row(OP_DRAW_SET, 63,  0,  0, 63, 16'h0000, 0, 16'h0000); // anti-diagonal to zero
      add_row(OP_READ,     63,  0,  0,  0, 16'h0000, 1, 16'h0000);
      add_row(OP_READ,      0, 63,  0,  0, 16'h0000, 1, 16'h0000);
      add_row(OP_READ,     32, 31,  0,  0, 16'h0000, 0, 16'h0000);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i])
         send_item(directed_q[i].op, directed_q[i].sx, directed_q[i].sy, directed_q[i].ex,
                   directed_q[i].ey, directed_q[i].value, directed_q[i].known,
                   directed_q[i].known_data);
      wait_drained();

      send_idle_pct = 25;
      recv_idle_pct = 58;
      send_random(ITEMS_PER_PHASE);
      wait_drained();

      send_idle_pct = 58;
      recv_idle_pct = 25;
      send_random(ITEMS_PER_PHASE);
      wait_drained();

      // no idling; receiver stalls at the start so the queue backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      send_random(ITEMS_PER_PHASE);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (cell_data_expect_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses missing, expected cell_data %h first", $time,
                  cell_data_expect_q.size(), cell_data_expect_q[0]);
      end
      if (error_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // Watchdog
   initial begin
      #6_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
